>>> hdl/tlf_pkg.sv
`default_nettype none

package tlf_pkg;

  localparam int unsigned MAX_WIDTH   = 63;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned FILL_W      = 7;

  localparam logic [7:0] NL_BYTE    = 8'd10;
  localparam logic [7:0] SPACE_BYTE = 8'd32;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_PUNCT_BREAKS = 1'b1
  } reg_idx_t;

  function automatic logic is_break(input logic [7:0] b, input logic punct);
    logic p;
    p = ((b >= 8'd33) && (b <= 8'd47)) || ((b >= 8'd58) && (b <= 8'd64)) ||
        ((b >= 8'd91) && (b <= 8'd96)) || ((b >= 8'd123) && (b <= 8'd126));
    return (b == SPACE_BYTE) || (punct && p);
  endfunction

endpackage

`default_nettype wire

>>> hdl/text_line_folder.sv
// Channel | Direction | tdata          | tuser  | tlast
// in_     | slave     | [7:0] ch       | kind   | -
// out_    | master     | [7:0] out_char | -      | last
// cfg_    | write     | wdata [5:0], addr 0 line_width, 1 punct_breaks
//
// A plain append keeps in_tready high, so appends run back to back.
// A fold walks the line store back from width-1, one byte per S_SRD/S_SCHK pass on
// the single store read port, then emits each byte via S_RD, S_LD, stalling S_WAIT.
// A flush emits in the same way; the item ends when the newline is taken.
// rst_n is synchronous; the store itself is not cleared, a fill count guards it.
`default_nettype none

module text_line_folder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic       in_tuser,   // [0] kind
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast,
  input  wire logic       cfg_we,
  input  wire logic       cfg_addr,
  input  wire logic [5:0] cfg_wdata
);
  import tlf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCHK,
    S_RD,
    S_LD,
    S_WAIT,
    S_NLW
  } state_t;

  state_t              state_r, state_nxt;
  logic [5:0]          line_width_r;
  logic                punct_r;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FILL_W-1:0]   total_r, total_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]   cut_r, cut_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [7:0]          odata_r, odata_nxt;
  logic                olast_r, olast_nxt;

  logic [7:0]          store [STORE_DEPTH];
  logic [7:0]          rdata_r;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   waddr;
  logic                we;
  logic [ADDR_W-1:0]   w_eff;
  logic                in_acc;
  logic                flush;

  always_comb begin
    w_eff = (line_width_r == 6'd0) ? 6'd1 : line_width_r;
    if (w_eff > ADDR_W'(MAX_WIDTH)) begin
      w_eff = ADDR_W'(MAX_WIDTH);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign flush     = (in_tuser == KIND_END) || (in_tdata == NL_BYTE);
  assign raddr     = head_r + idx_r;
  assign waddr     = head_r + fill_r[ADDR_W-1:0];
  assign we        = in_acc && !flush;

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= in_tdata;
    end
    rdata_r <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= 6'd63;
      punct_r      <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_LINE_WIDTH:   line_width_r <= cfg_wdata;
        REG_PUNCT_BREAKS: punct_r      <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    total_nxt  = total_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    cut_nxt    = cut_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          if (flush) begin
            total_nxt = fill_r;
            cut_nxt   = fill_r[ADDR_W-1:0];
            state_nxt = S_RD;
          end else if (fill_r < {1'b0, w_eff}) begin
            fill_nxt = fill_r + FILL_W'(1);
          end else begin
            total_nxt = fill_r + FILL_W'(1);
            cut_nxt   = w_eff;
            if (w_eff == 6'd1) begin
              state_nxt = S_RD;
            end else begin
              idx_nxt   = w_eff - 6'd1;
              state_nxt = S_SRD;
            end
          end
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (is_break(rdata_r, punct_r)) begin
          cut_nxt   = idx_r;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end else if (idx_r == 6'd1) begin
          idx_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          idx_nxt   = idx_r - 6'd1;
          state_nxt = S_SRD;
        end
      end
      S_RD: begin
        if (idx_r == cut_r) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = NL_BYTE;
          olast_nxt  = 1'b1;
          state_nxt  = S_NLW;
        end else begin
          state_nxt = S_LD;
        end
      end
      S_LD: begin
        ovalid_nxt = 1'b1;
        odata_nxt  = rdata_r;
        olast_nxt  = 1'b0;
        idx_nxt    = idx_r + 6'd1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = S_RD;
        end
      end
      S_NLW: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          head_nxt   = head_r + cut_r;
          fill_nxt   = total_r - {1'b0, cut_r};
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      head_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      head_r   <= head_nxt;
      ovalid_r <= ovalid_nxt;
    end
    total_r <= total_nxt;
    idx_r   <= idx_nxt;
    cut_r   <= cut_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("in_tready while an item is pending on out_");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_r[FILL_W-1])
    else $error("fill count above store limit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready after the final item of a line");
`endif

endmodule

`default_nettype wire

>>> test/text_line_folder_tb.sv
`timescale 1ns / 100ps

module text_line_folder_tb;
  import tlf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic        kind;
    reg_idx_t    addr;
    logic [7:0]  val;
    logic [2:0]  n_typed;
    logic [31:0] typed;
  } dir_row_t;

  localparam logic [2:0] BY_MODEL = 3'd7;
  localparam int         N_DIR    = 29;
  localparam int         N_PHASE  = 8;
  localparam int         PHASE_N  = 50;

  // typed results: first byte in the low bits, the newline is the final one
  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    '{ROW_ITEM, KIND_END,  REG_LINE_WIDTH,   8'h00, 3'd1, 32'h0000000A},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h0A, 3'd1, 32'h0000000A},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h61, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'hFF, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h00, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_END,  REG_LINE_WIDTH,   8'hFF, 3'd4, 32'h0A00FF61},
    '{ROW_CFG,  KIND_TEXT, REG_LINE_WIDTH,   8'h00, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h78, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h79, 3'd2, 32'h00000A78},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h80, 3'd2, 32'h00000A79},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h0A, 3'd2, 32'h00000A80},
    '{ROW_CFG,  KIND_TEXT, REG_LINE_WIDTH,   8'h04, 3'd0, 32'h00000000},
    '{ROW_CFG,  KIND_TEXT, REG_PUNCT_BREAKS, 8'h01, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h61, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h2C, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h62, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h63, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h64, BY_MODEL, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h20, BY_MODEL, 32'h00000000},
    '{ROW_CFG,  KIND_TEXT, REG_LINE_WIDTH,   8'h3F, 3'd0, 32'h00000000},
    '{ROW_CFG,  KIND_TEXT, REG_PUNCT_BREAKS, 8'h00, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h70, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h71, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h20, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h72, 3'd0, 32'h00000000},
    '{ROW_CFG,  KIND_TEXT, REG_LINE_WIDTH,   8'h02, 3'd0, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h73, BY_MODEL, 32'h00000000},
    '{ROW_ITEM, KIND_TEXT, REG_LINE_WIDTH,   8'h7A, BY_MODEL, 32'h00000000},
    '{ROW_ITEM, KIND_END,  REG_LINE_WIDTH,   8'h00, BY_MODEL, 32'h00000000}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = KIND_TEXT;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_addr = 1'b0;
  logic [5:0] cfg_wdata = 6'd0;

  text_line_folder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // line model
  logic [7:0] line_buf [0:STORE_DEPTH-1];
  int         line_len;
  logic [5:0] width_cfg;
  logic       punct_cfg;

  out_beat_t  fold_out [$];
  out_beat_t  chars_due [$];
  out_beat_t  typed_due [$];
  out_beat_t  due_b;
  bit         typed_on = 1'b0;
  bit         gaps_on = 1'b1;

  int items_taken = 0;
  int chars_checked = 0;
  int fold_cnt = 0;
  int flush_cnt = 0;
  int bad_cnt = 0;

  function automatic bit is_fold_point(input logic [7:0] b);
    bit p;
    p = (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
        (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    return (b == SPACE_BYTE) || (punct_cfg && p);
  endfunction

  task automatic fold_predict(input logic kind, input logic [7:0] ch);
    int w;
    int cut;
    int total;
    int i;
    fold_out.delete();
    w = (width_cfg == 6'd0) ? 1 : int'(width_cfg);
    if (kind == KIND_END || ch == NL_BYTE) begin
      for (i = 0; i < line_len; i++) fold_out.push_back('{line_buf[i], 1'b0});
      fold_out.push_back('{NL_BYTE, 1'b1});
      line_len = 0;
      flush_cnt++;
    end else if (line_len < w) begin
      line_buf[line_len] = ch;
      line_len++;
    end else begin
      line_buf[line_len] = ch;
      total = line_len + 1;
      cut = w;
      for (i = w - 1; i >= 1 && cut == w; i--)
        if (is_fold_point(line_buf[i])) cut = i;
      for (i = 0; i < cut; i++) fold_out.push_back('{line_buf[i], 1'b0});
      fold_out.push_back('{NL_BYTE, 1'b1});
      for (i = 0; i < total - cut; i++) line_buf[i] = line_buf[i + cut];
      line_len = total - cut;
      fold_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        fold_predict(in_tuser, in_tdata);
        items_taken++;
        if (typed_on) begin
          foreach (typed_due[j]) chars_due.push_back(typed_due[j]);
        end else begin
          foreach (fold_out[j]) chars_due.push_back(fold_out[j]);
        end
      end
      if (out_tvalid && out_tready) begin
        if (chars_due.size() == 0) begin
          if (bad_cnt < 10)
            $display("unexpected output char %02h last %0b", out_tdata, out_tlast);
          bad_cnt++;
        end else begin
          due_b = chars_due.pop_front();
          if (due_b.ch !== out_tdata || due_b.last !== out_tlast) begin
            if (bad_cnt < 10)
              $display("mismatch at output %0d: exp char %02h last %0b, got char %02h last %0b",
                       chars_checked, due_b.ch, due_b.last, out_tdata, out_tlast);
            bad_cnt++;
          end
        end
        chars_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (gaps_on) begin
      out_tready <= ($urandom_range(0, 99) >= 17);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_item(input logic kind, input logic [7:0] ch);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = ch;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (chars_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t addr, input logic [5:0] val);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val;
    if (addr == REG_LINE_WIDTH) width_cfg = val;
    else punct_cfg = val[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // text-like bytes; long phases rarely break so lines reach the full width
  task automatic next_text(input bit longish, output logic kind, output logic [7:0] ch);
    int r;
    int p_end;
    int p_nl;
    int p_sp;
    int p_pu;
    p_end = longish ? 5 : 20;
    p_nl  = longish ? 5 : 40;
    p_sp  = longish ? 15 : 150;
    p_pu  = longish ? 10 : 100;
    r = $urandom_range(0, 999);
    kind = KIND_TEXT;
    if (r < p_end) begin
      kind = KIND_END;
      ch = 8'($urandom_range(0, 255));
    end else if (r < p_end + p_nl) begin
      ch = NL_BYTE;
    end else if (r < p_end + p_nl + p_sp) begin
      ch = SPACE_BYTE;
    end else if (r < p_end + p_nl + p_sp + p_pu) begin
      case ($urandom_range(0, 3))
        0: ch = 8'($urandom_range(33, 47));
        1: ch = 8'($urandom_range(58, 64));
        2: ch = 8'($urandom_range(91, 96));
        default: ch = 8'($urandom_range(123, 126));
      endcase
    end else if (r < p_end + p_nl + p_sp + p_pu + 120) begin
      ch = 8'($urandom_range(0, 255));
    end else begin
      ch = 8'($urandom_range(97, 122));
    end
  endtask

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int         r;
    int         j;
    int         ph;
    logic       kind;
    logic [7:0] ch;
    logic [5:0] w;
    logic       pu;
    bit         longish;

    width_cfg = 6'd63;
    punct_cfg = 1'b0;
    line_len = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    for (r = 0; r < N_DIR; r++) begin
      if (DIR_TAB[r].op == ROW_CFG) begin
        wait_idle();
        cfg_write(DIR_TAB[r].addr, DIR_TAB[r].val[5:0]);
      end else begin
        typed_due.delete();
        if (DIR_TAB[r].n_typed != BY_MODEL) begin
          for (j = 0; j < DIR_TAB[r].n_typed; j++)
            typed_due.push_back('{DIR_TAB[r].typed[8*j +: 8], j == DIR_TAB[r].n_typed - 1});
          typed_on = 1'b1;
        end
        push_item(DIR_TAB[r].kind, DIR_TAB[r].val);
        typed_on = 1'b0;
      end
    end

    for (ph = 0; ph < N_PHASE; ph++) begin
      longish = 1'b0;
      gaps_on = 1'b1;
      case (ph)
        0: begin w = 6'd63; pu = 1'b0; longish = 1'b1; end
        1: begin w = 6'd1;  pu = 1'b1; end
        2: begin w = 6'd0;  pu = 1'b0; end
        3: begin
          w = 6'($urandom_range(0, 63));
          pu = 1'($urandom_range(0, 1));
          gaps_on = 1'b0;
        end
        4: begin w = 6'd63; pu = 1'b1; longish = 1'b1; end
        5: begin w = 6'($urandom_range(2, 10)); pu = 1'b1; end
        6: begin w = 6'($urandom_range(0, 63)); pu = 1'b0; end
        default: begin w = 6'd63; pu = 1'b0; longish = 1'b1; end
      endcase
      wait_idle();
      cfg_write(REG_LINE_WIDTH, w);
      cfg_write(REG_PUNCT_BREAKS, {5'd0, pu});
      for (j = 0; j < PHASE_N; j++) begin
        next_text(longish, kind, ch);
        push_item(kind, ch);
      end
    end

    gaps_on = 1'b1;
    while (chars_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d items taken, %0d output chars checked, %0d folds, %0d line flushes",
             items_taken, chars_checked, fold_cnt, flush_cnt);
    $display("widths 0, 1, 2, 4, 63 and random, punctuation breaks on and off, %0d bad",
             bad_cnt);
    if (bad_cnt == 0 && chars_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
